// ----- src/frame_interpolation_picker_core_macros.svh -----
// Assertion macros shared by the frame interpolation picker checkers.
// Include by bare file name; each macro expands to one labeled concurrent assertion.
`ifndef FRAME_INTERPOLATION_PICKER_CORE_MACROS_SVH
`define FRAME_INTERPOLATION_PICKER_CORE_MACROS_SVH

// Assertion sampled on clk, off while rst is high
`define FIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion sampled on clk that also covers the reset cycles
`define FIP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/fip_pkg.sv -----
// Shared types and codes of the frame interpolation picker.
// No dependencies; used by every module of the block by scoped names.
package fip_pkg;

  localparam int TIME_W   = 48;
  localparam int PERIOD_W = 32;
  localparam int WEIGHT_W = 16;
  localparam int SLOT_W   = 3;
  localparam int CHOICE_W = 2;
  localparam int CFG_W    = 48;
  localparam int DIV_CNT_W = $clog2(WEIGHT_W);

  // Item action codes
  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  // Present decision codes
  localparam logic [CHOICE_W-1:0] CHOICE_NONE   = 2'd0;
  localparam logic [CHOICE_W-1:0] CHOICE_BEFORE = 2'd1;
  localparam logic [CHOICE_W-1:0] CHOICE_AFTER  = 2'd2;
  localparam logic [CHOICE_W-1:0] CHOICE_BLEND  = 2'd3;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_PERIOD  = 2'd0,
    REG_FIRST_PRESENT = 2'd1,
    REG_BLEND_THRESH  = 2'd2,
    REG_BLEND_ENABLE  = 2'd3
  } reg_index_t;

  // Reset values of the configuration registers
  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 32'd166667;
  localparam logic [TIME_W-1:0]   FIRST_RESET   = 48'd0;
  localparam logic [WEIGHT_W-1:0] THRESH_RESET  = 16'd6554;
  localparam logic                ENABLE_RESET  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [TIME_W-1:0] time_stamp;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_written;
    logic                presented;
    logic [CHOICE_W-1:0] choice;
    logic [SLOT_W-1:0]   before_slot;
    logic [SLOT_W-1:0]   after_slot;
    logic [WEIGHT_W-1:0] blend_weight;
    logic [TIME_W-1:0]   target_time;
  } result_t;

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- src/fip_ring_mem.sv -----
// Timestamp ring memory with per-entry valid flags and a registered read.
// Depends on fip_pkg for the timestamp width.
module fip_ring_mem #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [$clog2(HISTORY_DEPTH)-1:0] waddr,
  input  logic [fip_pkg::TIME_W-1:0]     wdata,
  input  logic                           re,
  input  logic [$clog2(HISTORY_DEPTH)-1:0] raddr,
  output logic [fip_pkg::TIME_W-1:0]     rdata,
  output logic                           rvalid
);

  logic [fip_pkg::TIME_W-1:0] mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0]   valid;

  // Write and registered read of the timestamp array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Mark entries as they get written; read the flag alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      if (re) begin
        rvalid <= valid[raddr];
      end
    end
  end

endmodule

// ----- src/fip_div.sv -----
// Restoring divider: one quotient bit a cycle, 16 bits of 0.16 weight.
// Depends on fip_pkg for widths and the status struct.
module fip_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fip_pkg::TIME_W-1:0]    dividend,
  input  logic [fip_pkg::TIME_W:0]      divisor,
  output logic [fip_pkg::WEIGHT_W-1:0]  quotient,
  output fip_pkg::div_status_t          status
);

  localparam int REM_W = fip_pkg::TIME_W + 1;

  logic [REM_W-1:0]              rem;
  logic [REM_W-1:0]              dvs;
  logic [fip_pkg::DIV_CNT_W-1:0] cnt;
  logic [REM_W:0]                shifted;
  logic                          fits;

  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, dvs};

  // Load on start, then shift and subtract once per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= status.busy && !start &&
                     (cnt == fip_pkg::DIV_CNT_W'(fip_pkg::WEIGHT_W - 1));
      if (start) begin
        status.busy <= 1'b1;
        cnt         <= '0;
        rem         <= {1'b0, dividend};
        dvs         <= divisor;
        quotient    <= '0;
      end else if (status.busy) begin
        rem      <= fits ? REM_W'(shifted - {1'b0, dvs}) : shifted[REM_W-1:0];
        quotient <= {quotient[fip_pkg::WEIGHT_W-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == fip_pkg::DIV_CNT_W'(fip_pkg::WEIGHT_W - 1)) begin
          status.busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- src/frame_interpolation_picker_core.sv -----
// Frame interpolation picker: timestamp ring, nearest-frame scan and blend decision.
// Depends on fip_pkg, fip_ring_mem and fip_div.
//
// Usage: requests enter on item (valid/stall); each gives exactly one result on
// result (valid/stall). A store request writes its capture time into the next ring
// slot and reports that slot; its result goes through ST_FINISH to the output register.
// A present-check request whose time is before the next present time returns an
// all-zero result. Otherwise the block reads every ring slot from the timestamp
// memory, one per cycle, to find the nearest frames before and after the target,
// then divides serially for the weight when blending and both frames exist.
// The memory scan and the 16-step divider set how long a check takes; one request
// is worked at a time and item_stall is high while it is in flight.
// The result sits in an output register: a stalled result holds steady, and
// the block takes the next request meanwhile, waiting only to hand over its
// own result. Reset empties the ring, sets the registers to their defaults
// and loads the next present time with FIRST_RESET. Configuration writes go
// through cfg_we/cfg_index/cfg_data; the user must make them only while no
// request is in flight, as the block does not enforce it.
module frame_interpolation_picker_core #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  fip_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output fip_pkg::result_t           result,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [fip_pkg::CFG_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam int TW    = fip_pkg::TIME_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_TAIL   = 6'b000100,
    ST_EVAL   = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers
  logic [fip_pkg::PERIOD_W-1:0] frame_period;
  logic [fip_pkg::WEIGHT_W-1:0] blend_thresh;
  logic                         blend_en;

  // Block state outside the memory
  logic [IDX_W-1:0] write_slot;
  logic [TW-1:0]    next_present;

  // Per-request working registers
  logic [TW-1:0]       now;
  logic [TW-1:0]       target;
  logic [IDX_W-1:0]    scan_addr;
  logic                cmp_vld;
  logic [IDX_W-1:0]    cmp_idx;
  logic                have_before;
  logic                have_after;
  logic [TW-1:0]       before_dist;
  logic [TW-1:0]       after_dist;
  logic [IDX_W-1:0]    before_idx;
  logic [IDX_W-1:0]    after_idx;
  fip_pkg::result_t    work;
  fip_pkg::result_t    store_res;

  // Memory and divider hookup
  logic                mem_we;
  logic                mem_re;
  logic [TW-1:0]       rd_data;
  logic                rd_valid;
  logic                div_start;
  logic [TW:0]         total;
  logic [fip_pkg::WEIGHT_W-1:0] div_q;
  fip_pkg::div_status_t         div_st;

  logic            accept;
  logic            out_load;
  logic            is_before;
  logic [TW-1:0]   dist_before;
  logic [TW-1:0]   dist_after;
  logic [TW:0]     adv_sum;
  logic [TW-1:0]   advanced;
  logic [TW-1:0]   advanced_next;
  logic [fip_pkg::WEIGHT_W:0] upper_limit;

  assign item_stall = rst | (state != ST_IDLE);
  assign accept     = item_valid & ~item_stall;
  assign mem_we     = accept & (item.action == fip_pkg::ACT_STORE);
  assign mem_re     = (state == ST_SCAN);
  assign total      = {1'b0, before_dist} + {1'b0, after_dist};
  assign div_start  = (state == ST_EVAL) & have_after & have_before & blend_en;
  assign out_load   = (state == ST_FINISH) & (~result_valid | ~result_stall);

  fip_ring_mem #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .we     (mem_we),
    .waddr  (write_slot),
    .wdata  (item.time_stamp),
    .re     (mem_re),
    .raddr  (scan_addr),
    .rdata  (rd_data),
    .rvalid (rd_valid)
  );

  fip_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (before_dist),
    .divisor  (total),
    .quotient (div_q),
    .status   (div_st)
  );

  // Distance of the scanned frame on either side of the target
  assign is_before   = rd_data <= target;
  assign dist_before = target - rd_data;
  assign dist_after  = rd_data - target;

  // Advance the present time with saturation, then raise it to now
  assign adv_sum       = {1'b0, target} + (TW + 1)'(frame_period);
  assign advanced      = adv_sum[TW] ? '1 : adv_sum[TW-1:0];
  assign advanced_next = (advanced < now) ? now : advanced;

  assign upper_limit = (fip_pkg::WEIGHT_W + 1)'(1 << fip_pkg::WEIGHT_W)
                     - {1'b0, blend_thresh};

  // Result of a store request: only the written slot is reported
  always_comb begin
    store_res = '0;
    store_res.slot_written = fip_pkg::SLOT_W'(write_slot);
  end

  // Configuration writes and present time
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period <= fip_pkg::PERIOD_RESET;
      blend_thresh <= fip_pkg::THRESH_RESET;
      blend_en     <= fip_pkg::ENABLE_RESET;
      next_present <= fip_pkg::FIRST_RESET;
    end else begin
      if (cfg_we) begin
        unique case (fip_pkg::reg_index_t'(cfg_index))
          fip_pkg::REG_FRAME_PERIOD:  frame_period <= cfg_data[fip_pkg::PERIOD_W-1:0];
          fip_pkg::REG_FIRST_PRESENT: next_present <= cfg_data[TW-1:0];
          fip_pkg::REG_BLEND_THRESH:  blend_thresh <= cfg_data[fip_pkg::WEIGHT_W-1:0];
          fip_pkg::REG_BLEND_ENABLE:  blend_en     <= cfg_data[0];
          default: ;
        endcase
      end else if (out_load && work.presented) begin
        next_present <= advanced_next;
      end
    end
  end

  // Fold each returned ring entry into the nearest-before/after search
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= mem_re;
    end
    cmp_idx <= scan_addr;
    if (accept) begin
      have_before <= 1'b0;
      have_after  <= 1'b0;
      before_dist <= '0;
      after_dist  <= '0;
      before_idx  <= '0;
      after_idx   <= '0;
    end else if (cmp_vld && rd_valid) begin
      if (is_before) begin
        if (!have_before || dist_before < before_dist) begin
          have_before <= 1'b1;
          before_dist <= dist_before;
          before_idx  <= cmp_idx;
        end
      end else begin
        if (!have_after || dist_after < after_dist) begin
          have_after <= 1'b1;
          after_dist <= dist_after;
          after_idx  <= cmp_idx;
        end
      end
    end
  end

  // Request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      write_slot <= '0;
      scan_addr  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            now       <= item.time_stamp;
            target    <= next_present;
            scan_addr <= '0;
            if (item.action == fip_pkg::ACT_STORE) begin
              work <= store_res;
              write_slot <= (write_slot == IDX_W'(HISTORY_DEPTH - 1)) ?
                            '0 : write_slot + 1'b1;
              state <= ST_FINISH;
            end else if (item.time_stamp < next_present) begin
              work  <= '0;
              state <= ST_FINISH;
            end else begin
              work  <= '0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_addr == IDX_W'(HISTORY_DEPTH - 1)) begin
            state <= ST_TAIL;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        ST_TAIL: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (!have_after) begin
            state <= ST_FINISH;
          end else begin
            work.presented   <= 1'b1;
            work.after_slot  <= fip_pkg::SLOT_W'(after_idx);
            work.before_slot <= have_before ? fip_pkg::SLOT_W'(before_idx) : '0;
            work.target_time <= target;
            if (div_start) begin
              state <= ST_DIV;
            end else begin
              work.choice <= have_before ? fip_pkg::CHOICE_BEFORE : fip_pkg::CHOICE_AFTER;
              state <= ST_FINISH;
            end
          end
        end
        ST_DIV: begin
          if (div_st.done) begin
            work.blend_weight <= div_q;
            if (div_q < blend_thresh) begin
              work.choice <= fip_pkg::CHOICE_BEFORE;
            end else if ({1'b0, div_q} > upper_limit) begin
              work.choice <= fip_pkg::CHOICE_AFTER;
            end else begin
              work.choice <= fip_pkg::CHOICE_BLEND;
            end
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (out_load) begin
      result <= work;
    end
  end

endmodule

// ----- src/fip_checker.sv -----
// Port-level checks of the frame interpolation picker, bound to the top level.
// Depends on fip_pkg and frame_interpolation_picker_core_macros.svh.
`include "frame_interpolation_picker_core_macros.svh"

module fip_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      item_valid,
  input logic                      item_stall,
  input logic                      result_valid,
  input logic                      result_stall,
  input fip_pkg::result_t          result
);

  logic req_take;
  logic res_held;
  logic dec_ok;
  logic plain_ok;

  // Handshake and field summaries used by the properties
  assign req_take = item_valid & ~item_stall;
  assign res_held = result_valid & result_stall;
  assign dec_ok   = (result.choice != fip_pkg::CHOICE_NONE) && (result.slot_written == '0);
  assign plain_ok = (result.choice == fip_pkg::CHOICE_NONE) && (result.blend_weight == '0)
                    && (result.target_time == '0);

  // Reset leaves no result pending
  `FIP_ASSERT_RST(a_reset_empty, rst |=> !result_valid, "result valid after reset")

  // A stalled result stays put
  `FIP_ASSERT(a_result_hold, res_held |=> result_valid && $stable(result), "stalled result changed")

  // One request in flight at a time
  `FIP_ASSERT(a_busy_after_req, req_take |=> item_stall, "second request taken while busy")

  // A present decision always names a choice and no store slot
  `FIP_ASSERT(a_presented_choice, result_valid && result.presented |-> dec_ok, "bad decision")

  // Without a present decision, the decision fields stay clear
  `FIP_ASSERT(a_plain_clean, result_valid && !result.presented |-> plain_ok, "stray decision")

endmodule

bind frame_interpolation_picker_core fip_checker u_fip_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
